[rtl/lpht_pkg.sv]
// ============================================================================
// lpht_pkg - shared definitions for the linear probing hash table
// Field widths, result codes and the result record that moves between the
// probe controller and the output register.
// ============================================================================
package lpht_pkg;

  // Default number of slots in the table.
  localparam int TABLE_SIZE_DEFAULT = 16;

  // Fixed payload widths.
  localparam int KEY_W    = 31;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;

  // Request kinds.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // Result codes.
  localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FOUND     = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
  } result_t;

endpackage

[rtl/lpht_hash.sv]
// ============================================================================
// lpht_hash - home slot computation
// Reduces a key modulo the table size. A power-of-two size is a mask that
// finishes in the cycle after start. Any other size multiplies by a reciprocal,
// then applies one correction step; quotient, estimate and result are registered in turn.
// ============================================================================
module lpht_hash #(
  parameter int DIVISOR = lpht_pkg::TABLE_SIZE_DEFAULT,
  parameter int AW      = $clog2(DIVISOR)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [lpht_pkg::KEY_W-1:0] key,
  output logic                     done,
  output logic [AW-1:0]            home
);

  localparam bit IS_POW2 = ((DIVISOR & (DIVISOR - 1)) == 0);
  localparam int KEY_W   = lpht_pkg::KEY_W;

  generate
    if (IS_POW2) begin : g_mask
      logic          valid;
      logic [AW-1:0] rem;

      always_ff @(posedge clk) begin
        if (rst) begin
          valid <= 1'b0;
        end else if (start) begin
          valid <= 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          rem <= key[AW-1:0];
        end
      end

      assign done = valid;
      assign home = rem;
    end else begin : g_recip
      // The quotient estimate floor(key * RECIP / 2^SHIFT) is the true
      // quotient or one below it, so the estimated remainder stays under
      // twice the divisor and only its low AW+1 bits are needed.
      localparam int          SHIFT = KEY_W + AW;
      localparam logic [31:0] RECIP = 32'((64'd1 << SHIFT) / 64'(DIVISOR));
      localparam logic [AW:0] D_EXT = (AW+1)'(DIVISOR);

      logic [KEY_W+31:0] prod;
      logic [AW:0]       q_lo;
      logic [AW:0]       key_lo;
      logic [AW:0]       rem_est;
      logic [AW-1:0]     rem;
      logic              v1;
      logic              v2;
      logic              v3;

      assign prod = {32'b0, key} * {{KEY_W{1'b0}}, RECIP};

      always_ff @(posedge clk) begin
        if (rst) begin
          v1 <= 1'b0;
          v2 <= 1'b0;
          v3 <= 1'b0;
        end else begin
          v1 <= start;
          v2 <= v1;
          v3 <= v2;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          q_lo   <= prod[SHIFT +: AW+1];
          key_lo <= key[AW:0];
        end
        if (v1) begin
          rem_est <= key_lo - q_lo * D_EXT;
        end
        if (v2) begin
          rem <= (rem_est >= D_EXT) ? AW'(rem_est - D_EXT) : rem_est[AW-1:0];
        end
      end

      assign done = v3;
      assign home = rem;
    end
  endgenerate

  a_home_in_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (home <= AW'(DIVISOR - 1)))
    else $error("home slot beyond table size");

endmodule

[rtl/lpht_slot_ram.sv]
// ============================================================================
// lpht_slot_ram - slot storage
// One write port and one read port; read data is registered, so it appears
// in the cycle after the address. Each word holds a live bit above the key.
// ============================================================================
module lpht_slot_ram #(
  parameter int DEPTH  = lpht_pkg::TABLE_SIZE_DEFAULT,
  parameter int AW     = $clog2(DEPTH),
  parameter int DATA_W = lpht_pkg::KEY_W + 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/lpht_out_reg.sv]
// ============================================================================
// lpht_out_reg - result holding register
// Holds one finished result until it is taken, and takes a new one in the
// same cycle that the held one leaves.
// ============================================================================
module lpht_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  lpht_pkg::result_t res,
  output logic              res_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output lpht_pkg::result_t out_res
);

  logic full;

  assign res_ready = !full || out_ready;
  assign out_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (res_valid && res_ready) begin
      full <= 1'b1;
    end else if (out_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

endmodule

[rtl/linear_probing_hash_table_top.sv]
// An accepted request is hashed to its home slot, then probes one slot per
// memory read (1 to TABLE_SIZE slots) until it stops, and its result moves into
// the output register. Sizes other than a power of two use the reciprocal modulo.
// Only one request is in flight at a time; the next is accepted once the result
// has been handed to the output register.
// Reset: a clearing pass writes every slot empty and accepts no requests.
// ============================================================================
// linear_probing_hash_table_top - open addressing hash table, linear probing
// Insert and search requests on keys, slots held in a synchronous memory.
// ============================================================================
module linear_probing_hash_table_top #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic [lpht_pkg::KEY_W-1:0]      key,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lpht_pkg::STATUS_W-1:0]   status,
  output logic [lpht_pkg::SLOT_W-1:0]     slot_index
);

  localparam int AW     = $clog2(TABLE_SIZE);
  localparam int KEY_W  = lpht_pkg::KEY_W;
  localparam int SLOT_W = lpht_pkg::SLOT_W;
  localparam int DATA_W = KEY_W + 1;

  // Controller states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [AW-1:0]     clr_addr;
  logic              op;
  logic [KEY_W-1:0]  key_q;
  logic [AW-1:0]     cur_addr;
  logic [AW-1:0]     cur_succ;
  logic [AW-1:0]     chk;
  lpht_pkg::result_t res_q;
  lpht_pkg::result_t res_next;
  lpht_pkg::result_t out_res;

  logic              hash_start;
  logic              hash_done;
  logic [AW-1:0]     hash_home;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              rd_live;
  logic [KEY_W-1:0]  rd_key;
  logic              last_probe;
  logic              probe_stop;
  logic [AW+SLOT_W-1:0] cur_ext;
  logic              res_ready;

  // A request enters only when the controller is free; the output register
  // lets the previous result wait without holding up the next request.
  assign in_ready   = (state == S_IDLE);
  assign hash_start = in_valid && in_ready;

  lpht_hash #(
    .DIVISOR (TABLE_SIZE),
    .AW      (AW)
  ) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (key),
    .done  (hash_done),
    .home  (hash_home)
  );

  // The memory is read every cycle. In the hash state it fetches the home
  // slot; while probing it fetches the slot after the one being examined,
  // so a probe that does not stop has its next slot ready in the next cycle.
  assign cur_succ  = (cur_addr == AW'(TABLE_SIZE - 1)) ? '0 : cur_addr + 1'b1;
  assign ram_raddr = (state == S_HASH) ? hash_home : cur_succ;

  assign rd_live = ram_rdata[KEY_W];
  assign rd_key  = ram_rdata[KEY_W-1:0];

  // The clearing pass marks every slot empty; afterwards an insert writes
  // its key into the first empty slot it reads. Only one request is ever in
  // flight and its write ends it, so a read never overlaps a write to the
  // same slot.
  assign ram_we    = (state == S_CLEAR) ||
                     ((state == S_PROBE) && (op == lpht_pkg::REQ_INSERT) && !rd_live);
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : cur_addr;
  assign ram_wdata = (state == S_CLEAR) ? '0 : {1'b1, key_q};

  lpht_slot_ram #(
    .DEPTH  (TABLE_SIZE),
    .AW     (AW),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The slot number is reported through its low four bits.
  assign cur_ext    = {{SLOT_W{1'b0}}, cur_addr};
  assign last_probe = (chk == AW'(TABLE_SIZE - 1));

  // Probe decision on the slot whose data has just come back.
  always_comb begin
    probe_stop          = 1'b0;
    res_next.status     = lpht_pkg::STATUS_NOT_FOUND;
    res_next.slot_index = '0;
    if (op == lpht_pkg::REQ_INSERT) begin
      if (!rd_live) begin
        probe_stop          = 1'b1;
        res_next.status     = lpht_pkg::STATUS_INSERTED;
        res_next.slot_index = cur_ext[SLOT_W-1:0];
      end else if (last_probe) begin
        probe_stop      = 1'b1;
        res_next.status = lpht_pkg::STATUS_FULL;
      end
    end else begin
      if (!rd_live) begin
        probe_stop = 1'b1;
      end else if (rd_key == key_q) begin
        probe_stop          = 1'b1;
        res_next.status     = lpht_pkg::STATUS_FOUND;
        res_next.slot_index = cur_ext[SLOT_W-1:0];
      end else if (last_probe) begin
        probe_stop = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == AW'(TABLE_SIZE - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (hash_start) begin
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (probe_stop) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Request payload and probe position.
  always_ff @(posedge clk) begin
    if (hash_start) begin
      op    <= req_type;
      key_q <= key;
    end
    if ((state == S_HASH) && hash_done) begin
      cur_addr <= hash_home;
      chk      <= '0;
    end else if (state == S_PROBE) begin
      if (probe_stop) begin
        res_q <= res_next;
      end else begin
        cur_addr <= cur_succ;
        chk      <= chk + 1'b1;
      end
    end
  end

  lpht_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (state == S_DONE),
    .res       (res_q),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign status     = out_res.status;
  assign slot_index = out_res.slot_index;

  // A result is only ever produced by the end of a probe sequence.
  a_done_from_probe: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && ($past(state) != S_DONE)) |-> ($past(state) == S_PROBE))
    else $error("result produced without a probe");

  // A finished result waits unchanged until the output register takes it.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && !res_ready) |=> ((state == S_DONE) && $stable(res_q)))
    else $error("pending result lost or changed");

  // An insert write into a slot ends the request at once.
  a_insert_ends_request: assert property (@(posedge clk) disable iff (rst)
    ((state == S_PROBE) && ram_we) |=> (state == S_DONE))
    else $error("probe continued after storing a key");

endmodule
